// ===== design/wtsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wtsg_pkg;

  localparam int unsigned DIV_STEPS = 10;
  localparam int unsigned DVD_W     = 26;
  localparam int unsigned DVS_W     = 16;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic signed [15:0] INVALID_SAMPLE = 16'sh8000;
  localparam logic [4:0]         MAX_THICKNESS  = 5'd16;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_PLOT_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_CENTER_VALUE = 3'd3;
  localparam logic [2:0] REG_HALF_SPAN    = 3'd4;
  localparam logic [2:0] REG_THICKNESS    = 3'd5;
  localparam logic [2:0] REG_POS_COLOR    = 3'd6;
  localparam logic [2:0] REG_NEG_COLOR    = 3'd7;

  typedef struct packed {
    logic [9:0]         origin_x;
    logic [9:0]         origin_y;
    logic [9:0]         plot_height;
    logic signed [15:0] center_value;
    logic [14:0]        half_span;
    logic [4:0]         thickness;
    logic [15:0]        pos_color;
    logic [15:0]        neg_color;
  } cfg_t;

  typedef enum logic [1:0] {
    RNG_IN,
    RNG_ABOVE,
    RNG_BELOW
  } range_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== design/wtsg_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wtsg_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output logic              cfg_ready,
  output wtsg_pkg::cfg_t    cfg
);
  import wtsg_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.plot_height  <= 10'd1;
      cfg_r.center_value <= '0;
      cfg_r.half_span    <= 15'd1;
      cfg_r.thickness    <= '0;
      cfg_r.pos_color    <= '0;
      cfg_r.neg_color    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:     cfg_r.origin_x     <= cfg_data[9:0];
        REG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_data[9:0];
        REG_PLOT_HEIGHT:  cfg_r.plot_height  <= cfg_data[9:0];
        REG_CENTER_VALUE: cfg_r.center_value <= $signed(cfg_data);
        REG_HALF_SPAN:    cfg_r.half_span    <= cfg_data[14:0];
        REG_THICKNESS:    cfg_r.thickness    <= cfg_data[4:0];
        REG_POS_COLOR:    cfg_r.pos_color    <= cfg_data;
        REG_NEG_COLOR:    cfg_r.neg_color    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/wtsg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wtsg_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [wtsg_pkg::DVD_W-1:0]    dividend,
  input  wire logic [wtsg_pkg::DVS_W-1:0]    divisor,
  output logic                               done,
  output logic [wtsg_pkg::DIV_STEPS-1:0]     quotient
);
  import wtsg_pkg::*;

  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DVS_W+1:0]     shifted;
  logic [DVS_W+1:0]     trial;

  assign shifted  = {1'b0, rem_r, quo_r[DIV_STEPS-1]};
  assign trial    = shifted - {2'b00, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DVD_W-1:DIV_STEPS];
      quo_r <= dividend[DIV_STEPS-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!trial[DVS_W+1]) begin
        rem_r <= trial[DVS_W-1:0];
      end else begin
        rem_r <= shifted[DVS_W-1:0];
      end
      quo_r <= {quo_r[DIV_STEPS-2:0], ~trial[DVS_W+1]};
    end
  end

endmodule

`default_nettype wire

// ===== design/waveform_trace_span_generator_top.sv =====
// Each row mapping runs the multiply, the divider load, ten divider steps and divider done,
// then a settle state sets up the spans; the first span is offered once the sample is
// mapped in dot mode, and once the sample and the zero line are mapped in solid mode.
// One item at a time; a first sample maps only the sample; an item that emits nothing
// ends after the settle state; output stalls hold the item in the emit state.
// Reset (rst_n low, synchronous) restores register defaults, clears prev_row/col_pos.
`timescale 1ns / 1ps
`default_nettype none

module waveform_trace_span_generator_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_first,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [10:0]             out_column,
  output logic [10:0]             out_row_start,
  output logic [10:0]             out_row_end,
  output logic [15:0]             out_color,
  output logic                    out_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import wtsg_pkg::*;

  cfg_t     cfg;
  logic     div_start;
  logic     div_done;
  state_t   state_r, state_nxt;

  logic signed [15:0] smp_r;
  logic               first_r;
  logic               zero_pass_r;
  range_t             pos_r, zpos_r;
  logic [9:0]         rel_r, zrel_r;
  logic [DVD_W-1:0]   prod_r;
  logic [10:0]        prev_row_r, col_pos_r, col_base_r;
  logic [10:0]        rs_r, re_r;
  logic [15:0]        color_r;
  logic               dot_r;
  logic [4:0]         t_r;
  logic [3:0]         k_r;
  logic [DIV_STEPS-1:0] quotient;

  wtsg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  logic [14:0]        span;
  logic [15:0]        op;
  logic signed [17:0] top18, bot18, op18, diff18;
  range_t             cls;

  assign span   = (cfg.half_span == '0) ? 15'd1 : cfg.half_span;
  assign op     = zero_pass_r ? 16'd0 : smp_r;
  assign top18  = {{2{cfg.center_value[15]}}, cfg.center_value} + $signed({3'b000, span});
  assign bot18  = {{2{cfg.center_value[15]}}, cfg.center_value} - $signed({3'b000, span});
  assign op18   = {{2{op[15]}}, op};
  assign diff18 = top18 - op18;

  always_comb begin
    if (op18 > top18) begin
      cls = RNG_ABOVE;
    end else if (op18 < bot18) begin
      cls = RNG_BELOW;
    end else begin
      cls = RNG_IN;
    end
  end

  wtsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  ({span, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  logic [10:0] oy11, bottom, rowrel, zrow, cur, lo, hi, ys, ye, ys_raw, ye_raw;
  logic [4:0]  t_eff;
  logic [11:0] end12;
  logic [10:0] end11;
  logic        draw, valid_smp, need_zero, emit_go, out_acc, dot_mode;

  assign oy11      = {1'b0, cfg.origin_y};
  assign bottom    = oy11 + {1'b0, cfg.plot_height};
  assign rowrel    = oy11 + {1'b0, rel_r};
  assign zrow      = oy11 + {1'b0, zrel_r};
  assign t_eff     = (cfg.thickness > MAX_THICKNESS) ? MAX_THICKNESS : cfg.thickness;
  assign dot_mode  = (cfg.thickness != '0);
  assign valid_smp = (smp_r != INVALID_SAMPLE);
  assign need_zero = !zero_pass_r && !dot_mode && !first_r;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    case (pos_r)
      RNG_ABOVE: cur = oy11;
      RNG_BELOW: cur = bottom;
      default:   cur = rowrel;
    endcase
  end

  assign lo    = (cur < prev_row_r) ? cur : prev_row_r;
  assign hi    = (cur < prev_row_r) ? prev_row_r : cur;
  assign end12 = (lo < hi) ? ({1'b0, hi} + {7'b0, t_eff} - 12'd2)
                           : ({1'b0, lo} + {7'b0, t_eff} - 12'd1);
  assign end11 = end12[11] ? 11'h7FF : end12[10:0];

  always_comb begin
    draw   = 1'b1;
    ys_raw = '0;
    ye_raw = '0;
    case (pos_r)
      RNG_ABOVE: begin
        case (zpos_r)
          RNG_ABOVE: draw = 1'b0;
          RNG_BELOW: begin ys_raw = oy11; ye_raw = bottom; end
          default:   begin ys_raw = oy11; ye_raw = zrow; end
        endcase
      end
      RNG_BELOW: begin
        case (zpos_r)
          RNG_ABOVE: begin ys_raw = oy11; ye_raw = bottom; end
          RNG_BELOW: draw = 1'b0;
          default:   begin ys_raw = zrow; ye_raw = bottom; end
        endcase
      end
      default: begin
        case (zpos_r)
          RNG_ABOVE: begin ys_raw = oy11; ye_raw = rowrel; end
          RNG_BELOW: begin ys_raw = rowrel; ye_raw = bottom; end
          default:   begin ys_raw = zrow; ye_raw = rowrel; end
        endcase
      end
    endcase
  end

  assign ys = (ys_raw > ye_raw) ? ye_raw : ys_raw;
  assign ye = (ys_raw > ye_raw) ? ys_raw : ye_raw;

  assign emit_go = !first_r && valid_smp && (dot_mode ? (pos_r == RNG_IN) : draw);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = need_zero ? S_MUL : S_FIN;
      S_FIN:   state_nxt = emit_go ? S_EMIT : S_IDLE;
      S_EMIT:  if (out_acc && out_last) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_EMIT);
    div_start = (state_r == S_DIVGO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      prev_row_r <= '0;
      col_pos_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN) begin
        prev_row_r <= cur;
        col_pos_r  <= first_r ? ({1'b0, cfg.origin_x} + 11'd1) : (col_pos_r + 11'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smp_r       <= in_sample;
          first_r     <= in_first;
          zero_pass_r <= 1'b0;
        end
      end
      S_MUL: begin
        prod_r <= {10'd0, diff18[15:0]} * {16'd0, cfg.plot_height};
        if (zero_pass_r) begin
          zpos_r <= cls;
        end else begin
          pos_r <= cls;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (zero_pass_r) begin
            zrel_r <= quotient;
          end else begin
            rel_r <= quotient;
          end
          zero_pass_r <= need_zero;
        end
      end
      S_FIN: begin
        col_base_r <= col_pos_r;
        dot_r      <= dot_mode;
        t_r        <= t_eff;
        k_r        <= '0;
        if (dot_mode) begin
          rs_r    <= lo;
          re_r    <= end11;
          color_r <= cfg.pos_color;
        end else begin
          rs_r    <= ys;
          re_r    <= ye;
          color_r <= (smp_r > 16'sd0) ? cfg.pos_color : cfg.neg_color;
        end
      end
      S_EMIT: begin
        if (out_acc && !out_last) k_r <= k_r + 4'd1;
      end
      default: ;
    endcase
  end

  assign out_column    = col_base_r + {7'b0, k_r};
  assign out_row_start = rs_r;
  assign out_row_end   = re_r;
  assign out_color     = color_r;
  assign out_last      = !dot_r || ({1'b0, k_r} == (t_r - 5'd1));

endmodule

`default_nettype wire

// ===== bench/tb_waveform_trace_span_generator_top.sv =====
`timescale 1ns / 1ps

module tb_waveform_trace_span_generator_top;
  import wtsg_pkg::*;

  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 800000;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row_start;
    logic [10:0] row_end;
    logic [15:0] color;
    logic        last;
  } span_t;

  class span_scoreboard;
    cfg_t        regs;
    logic [10:0] prev_row;
    logic [10:0] col_pos;
    span_t       pending_spans[$];
    int          errors;
    int          checked;

    function new();
      regs = '{origin_x: '0, origin_y: '0, plot_height: 10'd1, center_value: '0,
               half_span: 15'd1, thickness: '0, pos_color: '0, neg_color: '0};
      prev_row = '0;
      col_pos = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_ORIGIN_X:     regs.origin_x = data[9:0];
        REG_ORIGIN_Y:     regs.origin_y = data[9:0];
        REG_PLOT_HEIGHT:  regs.plot_height = data[9:0];
        REG_CENTER_VALUE: regs.center_value = data;
        REG_HALF_SPAN:    regs.half_span = data[14:0];
        REG_THICKNESS:    regs.thickness = data[4:0];
        REG_POS_COLOR:    regs.pos_color = data;
        REG_NEG_COLOR:    regs.neg_color = data;
        default: ;
      endcase
    endfunction

    function range_t row_of(int value, output int rel);
      int span;
      int top;
      span = (regs.half_span == 0) ? 1 : int'(regs.half_span);
      top = int'($signed(regs.center_value)) + span;
      rel = 0;
      if (value > top) return RNG_ABOVE;
      if (value < int'($signed(regs.center_value)) - span) return RNG_BELOW;
      rel = ((top - value) * int'(regs.plot_height)) / (2 * span);
      return RNG_IN;
    endfunction

    function void push_span(int col, int rs, int re, logic [15:0] color, bit last);
      span_t s;
      if (re > 2047) re = 2047;
      s.column = 11'(col);
      s.row_start = 11'(rs);
      s.row_end = 11'(re);
      s.color = color;
      s.last = last;
      pending_spans.push_back(s);
    endfunction

    function void note_sample(logic signed [15:0] sample, logic mark);
      int     value, rel, zrel, cur, lo, hi, rend, t, top_row, bottom, ys, ye, swap;
      range_t zone, zzone;
      bit     draw, valid;
      value = int'(sample);
      valid = (sample != INVALID_SAMPLE);
      top_row = int'(regs.origin_y);
      bottom = top_row + int'(regs.plot_height);
      zone = row_of(value, rel);
      case (zone)
        RNG_BELOW: cur = bottom;
        RNG_ABOVE: cur = top_row;
        default:   cur = top_row + rel;
      endcase
      if (mark) begin
        prev_row = 11'(cur);
        col_pos = 11'(int'(regs.origin_x) + 1);
        return;
      end
      if (regs.thickness != 0) begin
        t = (regs.thickness > MAX_THICKNESS) ? int'(MAX_THICKNESS) : int'(regs.thickness);
        if (zone == RNG_IN && valid) begin
          lo = (cur < int'(prev_row)) ? cur : int'(prev_row);
          hi = (cur < int'(prev_row)) ? int'(prev_row) : cur;
          rend = (lo < hi) ? hi + t - 2 : lo + t - 1;
          for (int k = 0; k < t; k++)
            push_span(int'(col_pos) + k, lo, rend, regs.pos_color, k == t - 1);
        end
      end else begin
        zzone = row_of(0, zrel);
        draw = 1'b1;
        ys = 0;
        ye = 0;
        if (zone == RNG_ABOVE) begin
          if (zzone == RNG_ABOVE) draw = 1'b0;
          else if (zzone == RNG_BELOW) begin ys = top_row; ye = bottom; end
          else begin ys = top_row; ye = top_row + zrel; end
        end else if (zone == RNG_BELOW) begin
          if (zzone == RNG_ABOVE) begin ys = top_row; ye = bottom; end
          else if (zzone == RNG_BELOW) draw = 1'b0;
          else begin ys = top_row + zrel; ye = bottom; end
        end else begin
          if (zzone == RNG_ABOVE) begin ys = top_row; ye = top_row + rel; end
          else if (zzone == RNG_BELOW) begin ys = top_row + rel; ye = bottom; end
          else begin ys = top_row + zrel; ye = top_row + rel; end
        end
        if (ys > ye) begin
          swap = ys;
          ys = ye;
          ye = swap;
        end
        if (draw && valid)
          push_span(int'(col_pos), ys, ye, (value > 0) ? regs.pos_color : regs.neg_color, 1'b1);
      end
      prev_row = 11'(cur);
      col_pos = col_pos + 11'd1;
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        errors++;
        if (errors < 100)
          $display("%0t: span %s mismatch, expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_span(span_t got);
      span_t want;
      if (pending_spans.size() == 0) begin
        errors++;
        if (errors < 100)
          $display("%0t: unexpected span, expected none actual col %0d rows %0d..%0d",
                   $time, got.column, got.row_start, got.row_end);
        return;
      end
      want = pending_spans.pop_front();
      checked++;
      compare_field("column", want.column, got.column);
      compare_field("row_start", want.row_start, got.row_start);
      compare_field("row_end", want.row_end, got.row_end);
      compare_field("color", want.color, got.color);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_sample;
  logic               in_first;
  logic               out_valid;
  logic               out_ready;
  logic [10:0]        out_column;
  logic [10:0]        out_row_start;
  logic [10:0]        out_row_end;
  logic [15:0]        out_color;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  span_scoreboard sb = new();
  cfg_t           cur_plot;
  bit             sender_burst;
  bit             reader_burst;
  int             hold_cycles;
  int             accepted;
  int             settings;
  int             cycle_count;

  waveform_trace_span_generator_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_column    (out_column),
    .out_row_start (out_row_start),
    .out_row_end   (out_row_end),
    .out_color     (out_color),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("waveform_trace_span_generator_top regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    span_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen = '{column: out_column, row_start: out_row_start, row_end: out_row_end,
               color: out_color, last: out_last};
      sb.check_span(seen);
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = reader_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_sample(input logic signed [15:0] value, input logic mark);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= value;
    in_first <= mark;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(value, mark);
    accepted++;
  endtask

  // drop valid, drain every expected span, then let a silent item finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_plot(input cfg_t plot);
    logic [15:0] word [8];
    word[REG_ORIGIN_X]     = 16'(plot.origin_x);
    word[REG_ORIGIN_Y]     = 16'(plot.origin_y);
    word[REG_PLOT_HEIGHT]  = 16'(plot.plot_height);
    word[REG_CENTER_VALUE] = plot.center_value;
    word[REG_HALF_SPAN]    = 16'(plot.half_span);
    word[REG_THICKNESS]    = 16'(plot.thickness);
    word[REG_POS_COLOR]    = plot.pos_color;
    word[REG_NEG_COLOR]    = plot.neg_color;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= word[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(3'(i), word[i]);
    end
    cfg_valid <= 1'b0;
    cur_plot = plot;
    settings++;
  endtask

  function automatic cfg_t pick_plot();
    cfg_t plot;
    case ($urandom_range(0, 3))
      0: plot.origin_x = '0;
      1: plot.origin_x = '1;
      default: plot.origin_x = 10'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: plot.origin_y = '0;
      1: plot.origin_y = '1;
      default: plot.origin_y = 10'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: plot.plot_height = 10'd1;
      1: plot.plot_height = '1;
      default: plot.plot_height = 10'($urandom_range(1, 1023));
    endcase
    case ($urandom_range(0, 4))
      0: plot.center_value = 16'sh8000;
      1: plot.center_value = 16'sh7FFF;
      2: plot.center_value = '0;
      3: plot.center_value = 16'($urandom_range(0, 4000) - 2000);
      default: plot.center_value = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: plot.half_span = '0;
      1: plot.half_span = 15'd1;
      2: plot.half_span = '1;
      default: plot.half_span = 15'($urandom_range(1, 3000));
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2: plot.thickness = '0;
      3: plot.thickness = 5'd1;
      4: plot.thickness = MAX_THICKNESS;
      5: plot.thickness = '1;
      6: plot.thickness = 5'($urandom_range(2, 15));
      default: plot.thickness = 5'($urandom_range(17, 30));
    endcase
    plot.pos_color = 16'($urandom);
    plot.neg_color = 16'($urandom);
    return plot;
  endfunction

  function automatic logic signed [15:0] pick_sample(input cfg_t plot);
    int span, mid, v, roll;
    span = (plot.half_span == 0) ? 1 : int'(plot.half_span);
    mid = int'($signed(plot.center_value));
    roll = $urandom_range(0, 99);
    if (roll < 65) v = mid - span + int'($urandom_range(0, 2 * span));
    else if (roll < 75) v = mid + span + 1 + int'($urandom_range(0, 99));
    else if (roll < 83) v = mid - span - 1 - int'($urandom_range(0, 99));
    else if (roll < 88) v = ($urandom_range(0, 1) == 1) ? mid + span : mid - span;
    else if (roll < 93) return INVALID_SAMPLE;
    else return 16'($urandom);
    if (v > 32767 || v < -32768) return 16'($urandom);
    return 16'(v);
  endfunction

  task automatic run_phase(input cfg_t plot, input int count);
    settle();
    program_plot(plot);
    sender_burst = ($urandom_range(0, 3) == 0);
    reader_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 5) != 0) send_sample(pick_sample(plot), 1'b1);
    for (int k = 0; k < count; k++)
      send_sample(pick_sample(plot), $urandom_range(0, 24) == 0);
  endtask

  initial begin
    cfg_t plot;
    int   random_start;
    int   phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_first = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    sender_burst = 1'b0;
    reader_burst = 1'b0;
    hold_cycles = 0;
    accepted = 0;
    settings = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // straight out of reset, no first mark
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(INVALID_SAMPLE, 1'b0);

    // dot mode at the far corner: clipped rows, saturated row_end, invalid run
    settle();
    program_plot('{origin_x: '1, origin_y: '1, plot_height: '1, center_value: '0,
                   half_span: 15'd100, thickness: MAX_THICKNESS, pos_color: '1,
                   neg_color: '0});
    send_sample(16'sd0, 1'b1);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd101, 1'b0);
    send_sample(-16'sd101, 1'b0);
    send_sample(16'sd50, 1'b0);
    send_sample(16'sd50, 1'b0);
    sender_burst = 1'b1;
    repeat (20) send_sample(INVALID_SAMPLE, 1'b0);
    sender_burst = 1'b0;
    send_sample(16'sd20, 1'b0);
    send_sample(-16'sd20, 1'b0);

    // solid mode, zero line below the window
    settle();
    program_plot('{origin_x: '0, origin_y: '0, plot_height: '1, center_value: 16'sd1000,
                   half_span: 15'd10, thickness: '0, pos_color: 16'h1234,
                   neg_color: 16'h4321});
    send_sample(16'sd1000, 1'b1);
    send_sample(16'sd2000, 1'b0);
    send_sample(16'sd1005, 1'b0);
    send_sample(16'sd0, 1'b0);

    // solid mode, zero line above the window
    settle();
    program_plot('{origin_x: 10'd7, origin_y: 10'd3, plot_height: 10'd500,
                   center_value: -16'sd1000, half_span: 15'd10, thickness: '0,
                   pos_color: 16'h00FF, neg_color: 16'hFF00});
    send_sample(-16'sd1000, 1'b1);
    send_sample(16'sd2000, 1'b0);
    send_sample(-16'sd1005, 1'b0);
    send_sample(-16'sd5000, 1'b0);

    // zero span and oversized thickness
    settle();
    program_plot('{origin_x: 10'd512, origin_y: 10'd5, plot_height: 10'd1,
                   center_value: '0, half_span: '0, thickness: '1,
                   pos_color: 16'hA5A5, neg_color: 16'h5A5A});
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);

    random_start = accepted;
    phase = 0;
    while (accepted - random_start < RANDOM_ITEMS) begin
      if (phase == 2) begin
        // hold the output off while the input keeps coming
        plot = pick_plot();
        plot.thickness = MAX_THICKNESS;
        settle();
        program_plot(plot);
        sender_burst = 1'b1;
        reader_burst = 1'b0;
        send_sample(plot.center_value, 1'b1);
        hold_cycles = HOLD_CYCLES;
        repeat (30) send_sample(pick_sample(plot), 1'b0);
        sender_burst = 1'b0;
      end else if (phase == 5) begin
        run_phase(pick_plot(), 20);
        settle();
        repeat (20) send_sample(pick_sample(cur_plot), 1'b0);
      end else begin
        run_phase(pick_plot(), $urandom_range(15, 45));
      end
      phase++;
    end

    settle();
    if (sb.pending_spans.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected spans never arrived", $time, sb.pending_spans.size());
    end
    $display("%0d samples accepted, %0d spans checked across %0d register settings",
             accepted, sb.checked, settings);
    $display("dot and solid traces, clipping, invalid samples, saturated rows, output hold-off");
    if (sb.errors == 0) begin
      $display("waveform_trace_span_generator_top regression: pass");
    end else begin
      $display("waveform_trace_span_generator_top regression: fail");
    end
    $finish;
  end

endmodule
